// ===== hdl/imk_pkg.sv =====
// Shared types and constants of the iambic Morse keyer.
`timescale 1ns / 1ps

package imk_pkg;

   localparam int TICK_BITS      = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // keyer chain moves that may follow one another inside one tick
   localparam int KEYER_CHAIN_STEPS = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEYER_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIT_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAH_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_TICKS  = 2'd3;

   localparam logic [TICK_BITS-1:0] DIT_TICKS_RESET = 12'd66;
   localparam logic [TICK_BITS-1:0] DAH_TICKS_RESET = 12'd186;
   localparam logic [TICK_BITS-1:0] GAP_TICKS_RESET = 12'd54;

   typedef enum logic [1:0] {
      MODE_IAMBIC_A  = 2'd0,
      MODE_IAMBIC_B  = 2'd1,
      MODE_ULTIMATIC = 2'd2,
      MODE_STRAIGHT  = 2'd3
   } keyer_mode_type;

   typedef enum logic [2:0] {
      KS_IDLE   = 3'd0,
      KS_WAIT   = 3'd1,
      KS_DITCHK = 3'd2,
      KS_DAHCHK = 3'd3,
      KS_DOWN   = 3'd4,
      KS_UP     = 3'd5,
      KS_PAUSE  = 3'd6
   } keyer_state_type;

   typedef enum logic [1:0] {
      SG_UP   = 2'd0,
      SG_FALL = 2'd1,
      SG_ON   = 2'd2,
      SG_RISE = 2'd3
   } straight_gate_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DIT  = 2'd1,
      KIND_DAH  = 2'd2
   } element_kind_type;

   typedef struct packed {
      keyer_mode_type       keyer_mode;
      logic [TICK_BITS-1:0] dit_ticks;
      logic [TICK_BITS-1:0] dah_ticks;
      logic [TICK_BITS-1:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic dit_latch;
      logic dah_latch;
      logic dit_in_progress;
      logic release_pending;
      logic last_paddle_dah;
      logic elem_dah;
   } keyer_flags_type;

   typedef struct packed {
      keyer_state_type   keyer_state;
      straight_gate_type straight_gate;
      keyer_flags_type   flags;
   } keyer_ctl_type;

   localparam keyer_ctl_type KEYER_CTL_RESET = '{
      keyer_state:   KS_IDLE,
      straight_gate: SG_UP,
      flags:         '{dit_latch: 1'b0, dah_latch: 1'b0, dit_in_progress: 1'b0,
                       release_pending: 1'b1, last_paddle_dah: 1'b0, elem_dah: 1'b0}
   };

   typedef struct packed {
      logic dit_paddle;
      logic dah_paddle;
      logic direct_key;
   } req_word_type;

   typedef struct packed {
      logic             tone_gate;
      element_kind_type element_kind;
      logic             release_to_rx;
   } rsp_word_type;

endpackage

// ===== hdl/imk_ifaces.sv =====
// Valid/ready channel interfaces for the keyer tick and result words.
`timescale 1ns / 1ps

interface imk_req_if;
   logic valid;
   logic ready;
   logic dit_paddle;
   logic dah_paddle;
   logic direct_key;

   modport source (output valid, dit_paddle, dah_paddle, direct_key, input ready);
   modport sink   (input valid, dit_paddle, dah_paddle, direct_key, output ready);
endinterface

interface imk_rsp_if;
   logic       valid;
   logic       ready;
   logic       tone_gate;
   logic [1:0] element_kind;
   logic       release_to_rx;

   modport source (output valid, tone_gate, element_kind, release_to_rx, input ready);
   modport sink   (input valid, tone_gate, element_kind, release_to_rx, output ready);
endinterface

// ===== hdl/imk_csr.sv =====
// Configuration registers of the keyer: mode and element lengths.
`timescale 1ns / 1ps

module imk_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [imk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [imk_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output imk_pkg::cfg_type                    cfg
);
   import imk_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEYER_MODE: cfg_in.keyer_mode = keyer_mode_type'(csr_wdata[1:0]);
            CSR_DIT_TICKS:  cfg_in.dit_ticks  = csr_wdata[TICK_BITS-1:0];
            CSR_DAH_TICKS:  cfg_in.dah_ticks  = csr_wdata[TICK_BITS-1:0];
            CSR_GAP_TICKS:  cfg_in.gap_ticks  = csr_wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keyer_mode <= MODE_IAMBIC_A;
         cfg_ff.dit_ticks  <= DIT_TICKS_RESET;
         cfg_ff.dah_ticks  <= DAH_TICKS_RESET;
         cfg_ff.gap_ticks  <= GAP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/imk_step.sv =====
// One tick of keyer logic: straight-key gate, then the paddle keyer chain.
`timescale 1ns / 1ps

module imk_step #(
   parameter int TIMER_BITS = 12
) (
   input  imk_pkg::cfg_type        cfg,
   input  imk_pkg::req_word_type   word,
   input  imk_pkg::keyer_ctl_type  ctl,
   input  logic [TIMER_BITS-1:0]   timer,
   output imk_pkg::keyer_ctl_type  ctl_in,
   output logic [TIMER_BITS-1:0]   timer_in,
   output imk_pkg::rsp_word_type   result
);
   import imk_pkg::*;

   keyer_state_type       ks;
   straight_gate_type     sg;
   keyer_flags_type       fl;
   logic [TIMER_BITS-1:0] t;
   logic                  tone;
   element_kind_type      kind;
   logic                  rel;
   logic                  again;
   logic                  keyed;
   logic                  run_keyer;
   logic                  to_dah;
   logic                  iambic;

   always_comb begin
      ks        = ctl.keyer_state;
      sg        = ctl.straight_gate;
      fl        = ctl.flags;
      t         = timer;
      tone      = 1'b0;
      kind      = KIND_NONE;
      rel       = 1'b0;
      again     = 1'b1;
      to_dah    = 1'b0;
      run_keyer = 1'b0;
      iambic    = (cfg.keyer_mode == MODE_IAMBIC_A) || (cfg.keyer_mode == MODE_IAMBIC_B);
      keyed     = word.direct_key ||
                  ((cfg.keyer_mode == MODE_STRAIGHT) && (word.dit_paddle || word.dah_paddle));

      if (keyed) begin
         if (sg == SG_UP) sg = SG_RISE;
      end else if (sg != SG_UP) begin
         sg = SG_FALL;
      end

      if (sg != SG_UP) begin
         if (sg == SG_FALL) begin
            sg  = SG_UP;
            rel = 1'b1;
         end else begin
            sg   = SG_ON;
            tone = 1'b1;
         end
      end else begin
         run_keyer = (cfg.keyer_mode != MODE_STRAIGHT);
      end

      for (int i = 0; i < KEYER_CHAIN_STEPS; i++) begin
         if (run_keyer && again) begin
            again = 1'b0;
            unique case (ks)
               KS_IDLE: begin
                  if (word.dah_paddle) fl.dah_latch = 1'b1;
                  if (word.dit_paddle) fl.dit_latch = 1'b1;
                  if (fl.dit_latch || fl.dah_latch) begin
                     ks    = KS_WAIT;
                     again = 1'b1;
                  end else if (fl.release_pending) begin
                     fl.release_pending = 1'b0;
                     rel                = 1'b1;
                  end
               end
               KS_WAIT: begin
                  ks    = KS_DITCHK;
                  again = 1'b1;
               end
               KS_DITCHK: begin
                  if (fl.dit_latch) begin
                     fl.dit_in_progress = 1'b1;
                     fl.elem_dah        = 1'b0;
                     t                  = TIMER_BITS'(cfg.dit_ticks);
                     ks                 = KS_DOWN;
                  end else begin
                     ks = KS_DAHCHK;
                  end
                  again = 1'b1;
               end
               KS_DAHCHK: begin
                  if (fl.dah_latch) begin
                     fl.elem_dah = 1'b1;
                     t           = TIMER_BITS'(cfg.dah_ticks);
                     ks          = KS_DOWN;
                  end else begin
                     fl.release_pending = 1'b1;
                     ks                 = KS_IDLE;
                  end
                  again = 1'b1;
               end
               KS_DOWN: begin
                  tone = 1'b1;
                  kind = fl.elem_dah ? KIND_DAH : KIND_DIT;
                  if (t != '0) t = t - 1'b1;
                  fl.dit_latch = 1'b0;
                  fl.dah_latch = 1'b0;
                  ks           = KS_UP;
               end
               KS_UP: begin
                  if (t == '0) begin
                     t  = TIMER_BITS'(cfg.gap_ticks);
                     ks = KS_PAUSE;
                  end else begin
                     tone = 1'b1;
                     kind = fl.elem_dah ? KIND_DAH : KIND_DIT;
                     t    = t - 1'b1;
                     if (cfg.keyer_mode == MODE_IAMBIC_B) begin
                        if (word.dah_paddle) fl.dah_latch = 1'b1;
                        if (word.dit_paddle) fl.dit_latch = 1'b1;
                     end
                  end
               end
               KS_PAUSE: begin
                  if (word.dah_paddle) fl.dah_latch = 1'b1;
                  if (word.dit_paddle) fl.dit_latch = 1'b1;
                  t = t - 1'b1;
                  if (t == '0) begin
                     if (iambic) begin
                        to_dah = fl.dit_in_progress;
                     end else begin
                        if (!word.dit_paddle && word.dah_paddle) fl.last_paddle_dah = 1'b1;
                        if (word.dit_paddle && !word.dah_paddle) fl.last_paddle_dah = 1'b0;
                        to_dah = fl.dah_latch && !fl.last_paddle_dah;
                     end
                     if (to_dah) begin
                        fl.dit_latch       = 1'b0;
                        fl.dit_in_progress = 1'b0;
                        ks                 = KS_DAHCHK;
                     end else begin
                        fl.dah_latch       = 1'b0;
                        fl.release_pending = 1'b1;
                        ks                 = KS_IDLE;
                     end
                     again = 1'b1;
                  end
               end
               default: begin
                  ks = KS_IDLE;
               end
            endcase
         end
      end

      ctl_in.keyer_state   = ks;
      ctl_in.straight_gate = sg;
      ctl_in.flags         = fl;
      timer_in             = t;
      result.tone_gate     = tone;
      result.element_kind  = kind;
      result.release_to_rx = rel;
   end

endmodule

// ===== hdl/iambic_morse_keyer_unit.sv =====
// Iambic Morse keyer top level: input word register, keyer step, result register.
//
//   channel  dir  ports                            word
//   req      in   req_chan.valid/ready             dit_paddle, dah_paddle, direct_key
//   rsp      out  rsp_chan.valid/ready             tone_gate, element_kind, release_to_rx
//   csr      in   csr_wr_en, csr_index, csr_wdata  keyer_mode, dit/dah/gap_ticks
//
// One tick word per cycle unless rsp stalls; results go out from the result register.
// The keyer state, timer and result register update together in the one pass
// from the input register, so the keyer state loop sets the one-cycle rate.
// Synchronous active-high reset empties both registers and returns the keyer to idle.
// A stalled rsp holds the result; req keeps taking words until the input register fills.
`timescale 1ns / 1ps

module iambic_morse_keyer_unit #(
   parameter int TIMER_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   imk_req_if.sink                             req_chan,
   imk_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [imk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [imk_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import imk_pkg::*;

   cfg_type               cfg;
   req_word_type          req_word_ff;
   req_word_type          req_word_in;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          rsp_word_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   keyer_ctl_type         ctl_ff;
   keyer_ctl_type         ctl_in;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [TIMER_BITS-1:0] timer_in;
   logic                  advance;
   logic                  take;

   imk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   imk_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .cfg      (cfg),
      .word     (req_word_ff),
      .ctl      (ctl_ff),
      .timer    (timer_ff),
      .ctl_in   (ctl_in),
      .timer_in (timer_in),
      .result   (rsp_word_in)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      req_word_in.dit_paddle = req_chan.dit_paddle;
      req_word_in.dah_paddle = req_chan.dah_paddle;
      req_word_in.direct_key = req_chan.direct_key;
      in_valid_in            = req_chan.ready ? req_chan.valid : in_valid_ff;
      if (advance)             out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
      else                     out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= KEYER_CTL_RESET;
         timer_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctl_ff   <= ctl_in;
            timer_ff <= timer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) req_word_ff <= req_word_in;
      if (advance) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.tone_gate     = rsp_word_ff.tone_gate;
   assign rsp_chan.element_kind  = rsp_word_ff.element_kind;
   assign rsp_chan.release_to_rx = rsp_word_ff.release_to_rx;

`ifndef NO_ASSERTIONS
   a_tone_rel_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(rsp_word_ff.tone_gate && rsp_word_ff.release_to_rx))
      else $error("tone and release in one result word");

   a_kind_has_tone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_word_ff.element_kind != KIND_NONE) |-> rsp_word_ff.tone_gate)
      else $error("element kind without tone");

   a_rest_state: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.keyer_state == KS_IDLE || ctl_ff.keyer_state == KS_UP ||
      ctl_ff.keyer_state == KS_PAUSE)
      else $error("keyer chain left in a transient state");

   a_gate_rest: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.straight_gate == SG_UP || ctl_ff.straight_gate == SG_ON)
      else $error("straight gate left rising or falling");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the iambic Morse keyer: tick words in, keyed outputs checked.
`timescale 1ns / 1ps

module tb;
   import imk_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int LONG_HOLD   = 80;
   localparam int MAX_REPORTS = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_KEYER_MODE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   imk_req_if req_chan ();
   imk_rsp_if rsp_chan ();

   iambic_morse_keyer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // keyer mirror
   cfg_type           keyer_cfg;
   keyer_state_type   pad_state;
   straight_gate_type key_gate;
   logic [TICK_BITS-1:0] elem_timer;
   logic dit_held, dah_held, dit_active, release_due, last_lone_dah, elem_is_dah;

   req_word_type tick_words_q[$];
   rsp_word_type keyer_outputs_due[$];
   req_word_type tick_on_bus;

   int  send_gap, recv_hold, stalled_cycles;
   bit  sender_idles, receiver_idles;
   int  rx_hold_asked, rx_hold_done;
   int  words_sent, words_seen, mismatches, phases_run;
   int  tone_ticks, dit_ticks_seen, dah_ticks_seen, releases_seen;

   function automatic element_kind_type sounding_kind();
      if (elem_is_dah) return KIND_DAH;
      return KIND_DIT;
   endfunction

   function automatic rsp_word_type advance_keyer(req_word_type w);
      rsp_word_type r;
      logic         keyed;
      logic         again;
      logic         to_dah;
      int           passes;
      r.tone_gate     = 1'b0;
      r.element_kind  = KIND_NONE;
      r.release_to_rx = 1'b0;
      keyed = w.direct_key ||
              (keyer_cfg.keyer_mode == MODE_STRAIGHT && (w.dit_paddle || w.dah_paddle));
      if (keyed) begin
         if (key_gate == SG_UP) key_gate = SG_RISE;
      end else if (key_gate != SG_UP) begin
         key_gate = SG_FALL;
      end
      if (key_gate == SG_FALL) begin
         key_gate        = SG_UP;
         r.release_to_rx = 1'b1;
      end else if (key_gate != SG_UP) begin
         key_gate    = SG_ON;
         r.tone_gate = 1'b1;
      end else if (keyer_cfg.keyer_mode != MODE_STRAIGHT) begin
         again  = 1'b1;
         passes = 0;
         while (again && passes < 16) begin
            again = 1'b0;
            passes++;
            case (pad_state)
               KS_IDLE: begin
                  dit_held |= w.dit_paddle;
                  dah_held |= w.dah_paddle;
                  if (dit_held || dah_held) begin
                     pad_state = KS_WAIT;
                     again     = 1'b1;
                  end else if (release_due) begin
                     release_due     = 1'b0;
                     r.release_to_rx = 1'b1;
                  end
               end
               KS_WAIT: begin
                  pad_state = KS_DITCHK;
                  again     = 1'b1;
               end
               KS_DITCHK: begin
                  if (dit_held) begin
                     dit_active  = 1'b1;
                     elem_is_dah = 1'b0;
                     elem_timer  = keyer_cfg.dit_ticks;
                     pad_state   = KS_DOWN;
                  end else begin
                     pad_state = KS_DAHCHK;
                  end
                  again = 1'b1;
               end
               KS_DAHCHK: begin
                  if (dah_held) begin
                     elem_is_dah = 1'b1;
                     elem_timer  = keyer_cfg.dah_ticks;
                     pad_state   = KS_DOWN;
                  end else begin
                     release_due = 1'b1;
                     pad_state   = KS_IDLE;
                  end
                  again = 1'b1;
               end
               KS_DOWN: begin
                  r.tone_gate    = 1'b1;
                  r.element_kind = sounding_kind();
                  if (elem_timer != 0) elem_timer = elem_timer - 1'b1;
                  dit_held  = 1'b0;
                  dah_held  = 1'b0;
                  pad_state = KS_UP;
               end
               KS_UP: begin
                  if (elem_timer == 0) begin
                     elem_timer = keyer_cfg.gap_ticks;
                     pad_state  = KS_PAUSE;
                  end else begin
                     r.tone_gate    = 1'b1;
                     r.element_kind = sounding_kind();
                     elem_timer     = elem_timer - 1'b1;
                     if (keyer_cfg.keyer_mode == MODE_IAMBIC_B) begin
                        dit_held |= w.dit_paddle;
                        dah_held |= w.dah_paddle;
                     end
                  end
               end
               KS_PAUSE: begin
                  dit_held |= w.dit_paddle;
                  dah_held |= w.dah_paddle;
                  elem_timer = elem_timer - 1'b1;
                  if (elem_timer == 0) begin
                     if (keyer_cfg.keyer_mode == MODE_IAMBIC_A ||
                         keyer_cfg.keyer_mode == MODE_IAMBIC_B) begin
                        to_dah = dit_active;
                     end else begin
                        if (!w.dit_paddle && w.dah_paddle) last_lone_dah = 1'b1;
                        if (w.dit_paddle && !w.dah_paddle) last_lone_dah = 1'b0;
                        to_dah = dah_held && !last_lone_dah;
                     end
                     if (to_dah) begin
                        dit_held   = 1'b0;
                        dit_active = 1'b0;
                        pad_state  = KS_DAHCHK;
                     end else begin
                        dah_held    = 1'b0;
                        release_due = 1'b1;
                        pad_state   = KS_IDLE;
                     end
                     again = 1'b1;
                  end
               end
               default: pad_state = KS_IDLE;
            endcase
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(string field, int got, int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("word %0d: %s is %0d, predicted %0d", words_seen, field, got, want);
   endtask

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            keyer_outputs_due.push_back(advance_keyer(tick_on_bus));
            words_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (tick_words_q.size() > 0) begin
               tick_on_bus = tick_words_q.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.dit_paddle <= tick_on_bus.dit_paddle;
               req_chan.dah_paddle <= tick_on_bus.dah_paddle;
               req_chan.direct_key <= tick_on_bus.direct_key;
               send_gap = sender_idles ? idle_len() : 0;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (keyer_outputs_due.size() == 0) begin
               flag_mismatch("unexpected word, tone_gate", int'(rsp_chan.tone_gate), -1);
            end else begin
               rsp_word_type want;
               want = keyer_outputs_due.pop_front();
               if (rsp_chan.tone_gate !== want.tone_gate)
                  flag_mismatch("tone_gate", int'(rsp_chan.tone_gate), int'(want.tone_gate));
               if (rsp_chan.element_kind !== want.element_kind)
                  flag_mismatch("element_kind", int'(rsp_chan.element_kind),
                                int'(want.element_kind));
               if (rsp_chan.release_to_rx !== want.release_to_rx)
                  flag_mismatch("release_to_rx", int'(rsp_chan.release_to_rx),
                                int'(want.release_to_rx));
            end
            words_seen++;
            if (rsp_chan.tone_gate === 1'b1) tone_ticks++;
            if (rsp_chan.element_kind === KIND_DIT) dit_ticks_seen++;
            if (rsp_chan.element_kind === KIND_DAH) dah_ticks_seen++;
            if (rsp_chan.release_to_rx === 1'b1) releases_seen++;
         end
         if (rx_hold_asked != rx_hold_done) begin
            rx_hold_done = rx_hold_asked;
            recv_hold    = LONG_HOLD;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            recv_hold = idle_len();
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", stalled_cycles);
         $display("iambic_morse_keyer_unit: mismatch");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   task automatic queue_tick(logic dit, logic dah, logic key);
      req_word_type w;
      w.dit_paddle = dit;
      w.dah_paddle = dah;
      w.direct_key = key;
      tick_words_q.push_back(w);
   endtask

   // mostly held paddle patterns, some direct key runs, some noise
   task automatic queue_paddle_run(output int added);
      int       roll;
      int       len;
      logic [1:0] combo;
      roll  = $urandom_range(0, 99);
      combo = 2'($urandom_range(0, 3));
      if (roll < 12) begin
         len = $urandom_range(1, 6);
         repeat (len)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3) == 0);
      end else begin
         len = $urandom_range(1, 14);
         repeat (len) queue_tick(combo[0], combo[1], roll >= 94);
      end
      added = len;
   endtask

   task automatic wait_for_drain();
      while (tick_words_q.size() != 0 || req_chan.valid || keyer_outputs_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_keyer(keyer_mode_type mode, logic [TICK_BITS-1:0] dit,
                            logic [TICK_BITS-1:0] dah, logic [TICK_BITS-1:0] gap);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KEYER_MODE;
      csr_wdata <= {{(CSR_DATA_BITS-2){1'b0}}, mode};
      @(posedge clock);
      csr_index <= CSR_DIT_TICKS;
      csr_wdata <= dit;
      @(posedge clock);
      csr_index <= CSR_DAH_TICKS;
      csr_wdata <= dah;
      @(posedge clock);
      csr_index <= CSR_GAP_TICKS;
      csr_wdata <= gap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      keyer_cfg.keyer_mode = mode;
      keyer_cfg.dit_ticks  = dit;
      keyer_cfg.dah_ticks  = dah;
      keyer_cfg.gap_ticks  = gap;
   endtask

   task automatic run_phase(keyer_mode_type mode, logic [TICK_BITS-1:0] dit,
                            logic [TICK_BITS-1:0] dah, logic [TICK_BITS-1:0] gap,
                            int words, bit snd_idle, bit rcv_idle, bit long_hold);
      int queued;
      int added;
      wait_for_drain();
      set_keyer(mode, dit, dah, gap);
      sender_idles   = snd_idle;
      receiver_idles = rcv_idle;
      queued = 0;
      while (queued < words) begin
         queue_paddle_run(added);
         queued += added;
      end
      if (long_hold) rx_hold_asked++;
      phases_run++;
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.dit_paddle = 1'b0;
      req_chan.dah_paddle = 1'b0;
      req_chan.direct_key = 1'b0;
      rsp_chan.ready      = 1'b0;
      keyer_cfg     = '{keyer_mode: MODE_IAMBIC_A, dit_ticks: DIT_TICKS_RESET,
                        dah_ticks: DAH_TICKS_RESET, gap_ticks: GAP_TICKS_RESET};
      pad_state     = KS_IDLE;
      key_gate      = SG_UP;
      elem_timer    = '0;
      dit_held      = 1'b0;
      dah_held      = 1'b0;
      dit_active    = 1'b0;
      release_due   = 1'b1;
      last_lone_dah = 1'b0;
      elem_is_dah   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first release pulse, direct key on and off
      queue_tick(0, 0, 0);
      queue_tick(0, 0, 1);
      queue_tick(0, 0, 1);
      queue_tick(0, 0, 0);
      // zero dit length still sounds one tick
      run_phase(MODE_IAMBIC_A, 0, 1, 1, 0, 0, 0, 0);
      queue_tick(1, 1, 0);
      queue_tick(1, 1, 0);
      repeat (4) queue_tick(0, 0, 0);
      // mode B picks up dah pressed during the dit
      run_phase(MODE_IAMBIC_B, 2, 2, 1, 0, 0, 0, 0);
      queue_tick(1, 0, 0);
      queue_tick(0, 1, 0);
      repeat (4) queue_tick(0, 0, 0);
      run_phase(MODE_ULTIMATIC, 1, 1, 2, 0, 0, 0, 0);
      queue_tick(1, 1, 0);
      queue_tick(0, 1, 0);
      repeat (3) queue_tick(0, 0, 0);
      run_phase(MODE_STRAIGHT, 1, 1, 1, 0, 0, 0, 0);
      queue_tick(1, 0, 0);
      queue_tick(0, 0, 0);
      queue_tick(0, 1, 0);
      queue_tick(0, 0, 1);
      queue_tick(0, 0, 0);

      run_phase(MODE_IAMBIC_A,  2, 5, 2, 150, 1, 1, 0);
      run_phase(MODE_IAMBIC_B,  3, 6, 1, 150, 1, 1, 1);
      run_phase(MODE_ULTIMATIC, 1, 3, 2, 150, 1, 0, 0);
      run_phase(MODE_STRAIGHT,  2, 4, 1,  80, 0, 1, 0);
      run_phase(MODE_ULTIMATIC, 2, 4, 3, 150, 1, 1, 1);
      run_phase(MODE_IAMBIC_A,  0, 2, 1, 150, 0, 0, 0);
      run_phase(MODE_IAMBIC_B,  1, 1, 1, 150, 1, 1, 0);
      // zero gap: pause counter wraps to the top of the timer range
      run_phase(MODE_IAMBIC_B,  1, 2, 0, 40, 0, 0, 0);
      run_phase(MODE_IAMBIC_B,  4095, 4095, 4095, 60, 1, 1, 0);

      wait_for_drain();
      repeat (6) @(posedge clock);
      $display("%0d tick words over %0d setting phases, all four keyer modes", words_sent,
               phases_run);
      $display("%0d tone ticks (%0d dit, %0d dah), %0d release pulses", tone_ticks,
               dit_ticks_seen, dah_ticks_seen, releases_seen);
      if (mismatches == 0 && keyer_outputs_due.size() == 0 && words_seen == words_sent) begin
         $display("iambic_morse_keyer_unit: match");
      end else begin
         $display("iambic_morse_keyer_unit: mismatch");
      end
      $finish;
   end

endmodule
